// ===== rtl/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg: shared types and constants for the radix ASCII converter
// Modes, default sizes, digit alphabet and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package ira_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_MAX_DIGITS = 64;

  // Quotient bits resolved per divider cycle
  localparam int DIV_BITS = 4;

  // Input field widths fixed by the channel
  localparam int VALUE_W  = 64;
  localparam int RADIX_W  = 6;
  localparam int BUDGET_W = 7;
  localparam int CHAR_W   = 8;

  // Radix limits for general mode
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_HOLE = 6'd35;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

  // ASCII anchors
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] ASCII_LETTER = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

  typedef enum logic [1:0] {
    MODE_DEC     = 2'd0,
    MODE_HEX     = 2'd1,
    MODE_LETTER  = 2'd2,
    MODE_GENERAL = 2'd3
  } mode_t;

  // Sixteen-letter hex alphabet, digit 0 first
  localparam logic [CHAR_W-1:0] LETTER_HEX [16] = '{
    8'h51, 8'h42, 8'h50, 8'h56, 8'h46, 8'h5A, 8'h53, 8'h44,
    8'h54, 8'h4A, 8'h43, 8'h47, 8'h4B, 8'h59, 8'h58, 8'h57
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture a new transaction
    logic div_step;  // run one divider step
    logic store;     // write the finished digit
    logic rd;        // read the digit store
    logic cap;       // capture read data into the output register
    logic advance;   // step to the next lower digit index
  } ira_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic radix_bad;    // incoming radix invalid in general mode
    logic budget_zero;  // incoming budget is zero
    logic quo_zero;     // quotient after this digit is zero
    logic count_hit;    // this digit fills the budget
    logic out_last;     // output register holds the final character
  } ira_sts_t;

  // Map a digit value to its character
  function automatic logic [CHAR_W-1:0] digit_char(mode_t m, logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    begin
      if (m == MODE_LETTER) begin
        c = LETTER_HEX[d[3:0]];
      end else if (d < RADIX_DEC) begin
        c = ASCII_ZERO + CHAR_W'(d);
      end else begin
        c = ASCII_LETTER + CHAR_W'(d);
      end
      return c;
    end
  endfunction

endpackage

// ===== rtl/ira_in_if.sv =====
// ----------------------------------------------------------------------------
// ira_in_if: request channel of the radix ASCII converter
// Carries mode, value, radix and digit budget with valid/ready.
// ----------------------------------------------------------------------------
interface ira_in_if
  import ira_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [VALUE_W-1:0]  value;
  logic [RADIX_W-1:0]  radix;
  logic [BUDGET_W-1:0] digit_budget;

  modport source (output valid, output mode, output value, output radix,
                  output digit_budget, input ready);
  modport sink   (input valid, input mode, input value, input radix,
                  input digit_budget, output ready);
endinterface

// ===== rtl/ira_out_if.sv =====
// ----------------------------------------------------------------------------
// ira_out_if: character channel of the radix ASCII converter
// Carries one character with last and error flags, valid/ready.
// ----------------------------------------------------------------------------
interface ira_out_if
  import ira_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              error;

  modport source (output valid, output character, output last, output error,
                  input ready);
  modport sink   (input valid, input character, input last, input error,
                  output ready);
endinterface

// ===== rtl/ira_ram.sv =====
// ----------------------------------------------------------------------------
// ira_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ira_datapath.sv =====
// ----------------------------------------------------------------------------
// ira_datapath: divider, digit store and output register
// Shift-subtract divider resolving DIV_BITS quotient bits a cycle, digit
// store written lowest digit first and read back in reverse.
// ----------------------------------------------------------------------------
module ira_datapath
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  ira_cmd_t            cmd,
  output ira_sts_t            sts,
  input  logic [1:0]          mode,
  input  logic [VALUE_W-1:0]  value,
  input  logic [RADIX_W-1:0]  radix,
  input  logic [BUDGET_W-1:0] digit_budget,
  output logic [CHAR_W-1:0]   character,
  output logic                last,
  output logic                error
);

  localparam int STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int QW    = STEPS * DIV_BITS;
  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CW    = $clog2(MAX_DIGITS + 1);

  mode_t               cur_mode;
  logic [RADIX_W-1:0]  base;
  logic [CW-1:0]       budget;
  logic [QW-1:0]       quo;
  logic [RADIX_W-1:0]  rem;
  logic [CW-1:0]       count;
  logic [AW-1:0]       rd_idx;
  logic [CHAR_W-1:0]   rdata;

  logic [QW-1:0]       quo_next;
  logic [RADIX_W-1:0]  rem_next;
  logic [CW-1:0]       count_inc;
  logic [RADIX_W-1:0]  base_in;
  logic [CW-1:0]       budget_in;
  mode_t               mode_in;

  // Decode the incoming transaction
  always_comb begin
    mode_in = mode_t'(mode);
    case (mode_in)
      MODE_DEC:     base_in = RADIX_DEC;
      MODE_GENERAL: base_in = radix;
      default:      base_in = RADIX_HEX;
    endcase
    if (digit_budget > BUDGET_W'(MAX_DIGITS)) begin
      budget_in = CW'(MAX_DIGITS);
    end else begin
      budget_in = CW'(digit_budget);
    end
  end

  // Resolve DIV_BITS quotient bits; the remainder stays below the base
  always_comb begin
    logic [RADIX_W:0] t;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      t        = {rem_next, quo_next[QW-1]};
      quo_next = {quo_next[QW-2:0], 1'b0};
      if (t >= {1'b0, base}) begin
        t           = t - {1'b0, base};
        quo_next[0] = 1'b1;
      end
      rem_next = t[RADIX_W-1:0];
    end
  end

  assign count_inc = count + CW'(1);

  // Status back to the controller
  always_comb begin
    sts.radix_bad   = (mode_in == MODE_GENERAL) &&
                      ((radix < RADIX_MIN) || (radix > RADIX_MAX) ||
                       (radix == RADIX_HOLE));
    sts.budget_zero = (digit_budget == '0);
    sts.quo_zero    = (quo == '0);
    sts.count_hit   = (count_inc == budget);
    sts.out_last    = last;
  end

  // Conversion registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quo   <= '0;
      count <= '0;
    end else if (cmd.load) begin
      quo   <= QW'(value[VALUE_BITS-1:0]);
      count <= '0;
    end else if (cmd.div_step) begin
      quo   <= quo_next;
    end else if (cmd.store) begin
      count <= count_inc;
    end
  end

  // Transaction setup, remainder and read index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_mode <= mode_in;
      base     <= base_in;
      budget   <= budget_in;
      rem      <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end else if (cmd.store) begin
      rem    <= '0;
      rd_idx <= count[AW-1:0];
    end else if (cmd.advance) begin
      rd_idx <= rd_idx - AW'(1);
    end
  end

  // Digit store
  ira_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_DIGITS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(count[AW-1:0]),
    .wdata(digit_char(cur_mode, rem)),
    .re   (cmd.rd),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  // Output register; load presets the error character
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      character <= CHAR_NONE;
      last      <= 1'b1;
      error     <= 1'b1;
    end else if (cmd.cap) begin
      character <= rdata;
      last      <= (rd_idx == '0);
      error     <= 1'b0;
    end
  end

endmodule

// ===== rtl/ira_ctrl.sv =====
// ----------------------------------------------------------------------------
// ira_ctrl: sequencer of the radix ASCII converter
// Steps the divider per digit, stores digits, then reads them back and
// hands each character to the output channel.
// ----------------------------------------------------------------------------
module ira_ctrl
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ira_sts_t sts,
  output ira_cmd_t cmd
);

  localparam int STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_STORE = 6'b000100,
    ST_RD    = 6'b001000,
    ST_CAP   = 6'b010000,
    ST_SEND  = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [SW-1:0] step_cnt;
  logic          in_acc;
  logic          out_acc;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SEND);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          if (sts.radix_bad) begin
            state_next = ST_SEND;
          end else if (!sts.budget_zero) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == SW'(STEPS - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (sts.quo_zero || sts.count_hit) begin
          state_next = ST_RD;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap    = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_acc) begin
          if (sts.out_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and divider cycle count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        step_cnt <= step_cnt + SW'(1);
      end else begin
        step_cnt <= '0;
      end
    end
  end

  // A stored digit leads to another division or the read-back
  a_store_next: assert property (@(posedge clk) disable iff (rst)
    state == ST_STORE |=> (state == ST_DIV || state == ST_RD))
    else $error("store not followed by divide or read");

  // Each digit starts its division from a cleared cycle count
  a_step_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_STORE |=> step_cnt == '0)
    else $error("divider count not cleared between digits");

  // An invalid radix answers at once with the error character
  a_err_send: assert property (@(posedge clk) disable iff (rst)
    (in_acc && sts.radix_bad) |=> state == ST_SEND)
    else $error("invalid radix did not go to send");

  // A stalled character keeps the sequencer waiting
  a_send_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && !out_ready) |=> state == ST_SEND)
    else $error("left send without output transaction");

  // No new request is taken while a character is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output active together");

endmodule

// ===== rtl/integer_to_radix_ascii_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top: unsigned integer to ASCII digit converter
//
// Usage: in_ch carries one request transaction (mode, value, radix,
// digit_budget). out_ch returns the digits most significant first, one
// character per transaction, with last set on the final one. An invalid
// general-mode radix returns a single transaction with character zero,
// last and error set. A zero budget with a valid radix returns nothing.
// Flow: one request is worked at a time. Each digit passes through the
// shared shift-subtract divider and is then written to the digit store;
// each character is then read back from the digit store, registered and
// sent when the receiver is ready.
// Reset: rst returns the sequencer to idle; in_ch.ready is high the next
// cycle. When out_ch stalls, the pending character holds and no new
// request is taken until the final character is delivered.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input logic   clk,
  input logic   rst,
  ira_in_if.sink    in_ch,
  ira_out_if.source out_ch
);

  ira_cmd_t cmd;
  ira_sts_t sts;

  // Sequencer
  ira_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Divider, digit store and output register
  ira_datapath #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (in_ch.mode),
    .value       (in_ch.value),
    .radix       (in_ch.radix),
    .digit_budget(in_ch.digit_budget),
    .character   (out_ch.character),
    .last        (out_ch.last),
    .error       (out_ch.error)
  );

endmodule
